FILE: rtl/b256_pkg.sv
// Shared types, constants and tables of the BLAKE-256 compression core.
package b256_pkg;

    localparam int ROUNDS_DEF = 14;
    localparam int SIGMA_ROWS = 10;

    localparam logic [31:0] BLAKE_IV [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] BLAKE_C [0:15] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
        32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
        32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917
    };

    localparam logic [3:0] SIGMA [0:9][0:15] = '{
        '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
        '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
        '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
        '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
        '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
        '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
        '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
        '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
        '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
    };

    typedef struct packed {
        logic       load;
        logic       first_iv;
        logic       latch_cnt;
        logic       init;
        logic       pf_en;
        logic [3:0] pf_row;
        logic [3:0] pf_step;
        logic       g_en;
        logic       g_half;
        logic [2:0] g_step;
        logic       fin;
        logic [2:0] out_sel;
    } b256_cmd_t;

endpackage

FILE: rtl/blake256_hash_core.sv
// Top level of the BLAKE-256 compression core with its salt register port.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         start & !busy              message_word, bit_count, first/final_block
//   result    out        digest_valid per word      digest_word, digest_last
//   config    in         psel & penable & pwrite    paddr, pwdata (salt_0..salt_3)
//
// Words of a block are taken one per cycle while busy is low.
// After the sixteenth word the core is busy through init, the rounds and finalization
// (one half G step per cycle in a single G unit), and through the digest words if any follow.
// Reset loads the IV into the chaining value and clears the salt registers.
// The receiver cannot stall; each digest word is shown for one cycle.
module blake256_hash_core
    import b256_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] message_word,
    input  logic [63:0] bit_count,
    input  logic        first_block,
    input  logic        final_block,
    output logic        digest_valid,
    output logic [31:0] digest_word,
    output logic        digest_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0][31:0] salt_reg;
    b256_cmd_t        cmd;

    assign pready = 1'b1;
    assign prdata = salt_reg[paddr[3:2]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            salt_reg[paddr[3:2]] <= pwdata;
        end
    end

    b256_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .first_block  (first_block),
        .final_block  (final_block),
        .busy         (busy),
        .digest_valid (digest_valid),
        .digest_last  (digest_last),
        .cmd          (cmd)
    );

    b256_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_word (message_word),
        .bit_count    (bit_count),
        .salt         (salt_reg),
        .digest_word  (digest_word)
    );

endmodule

FILE: rtl/b256_ctrl.sv
// Sequencing state machine of the BLAKE-256 compression core.
module b256_ctrl
    import b256_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      first_block,
    input  logic      final_block,
    output logic      busy,
    output logic      digest_valid,
    output logic      digest_last,
    output b256_cmd_t cmd
);

    localparam int RW = $clog2(ROUNDS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [3:0]    word_idx_reg, word_idx_next;
    logic [3:0]    step_reg, step_next;
    logic [RW-1:0] round_reg, round_next;
    logic [2:0]    out_cnt_reg, out_cnt_next;
    logic          fin_reg, fin_next;
    logic [RW:0]   pf_round;
    logic [RW:0]   pf_round_m;

    always_comb
    begin
        pf_round   = (step_reg == 4'd15) ? ({1'b0, round_reg} + (RW+1)'(1))
                                         : {1'b0, round_reg};
        pf_round_m = (pf_round >= (RW+1)'(SIGMA_ROWS)) ? (pf_round - (RW+1)'(SIGMA_ROWS))
                                                       : pf_round;
    end

    always_comb
    begin
        state_next    = state_reg;
        word_idx_next = word_idx_reg;
        step_next     = step_reg;
        round_next    = round_reg;
        out_cnt_next  = out_cnt_reg;
        fin_next      = fin_reg;
        cmd           = '0;
        busy          = 1'b1;
        digest_valid  = 1'b0;
        digest_last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load      = 1'b1;
                    cmd.first_iv  = (word_idx_reg == 4'd0) && first_block;
                    word_idx_next = word_idx_reg + 4'd1;
                    if (word_idx_reg == 4'd15)
                    begin
                        cmd.latch_cnt = 1'b1;
                        fin_next      = final_block;
                        state_next    = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init    = 1'b1;
                cmd.pf_en   = 1'b1;
                cmd.pf_row  = 4'd0;
                cmd.pf_step = 4'd0;
                step_next   = 4'd0;
                round_next  = '0;
                state_next  = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.g_en    = 1'b1;
                cmd.g_half  = step_reg[0];
                cmd.g_step  = step_reg[3:1];
                cmd.pf_en   = 1'b1;
                cmd.pf_row  = 4'(pf_round_m);
                cmd.pf_step = step_reg + 4'd1;
                step_next   = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    round_next = round_reg + RW'(1);
                    if (round_reg == RW'(ROUNDS - 1))
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                cmd.fin      = 1'b1;
                out_cnt_next = 3'd0;
                state_next   = fin_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                digest_valid = 1'b1;
                digest_last  = (out_cnt_reg == 3'd7);
                cmd.out_sel  = out_cnt_reg;
                out_cnt_next = out_cnt_reg + 3'd1;
                if (out_cnt_reg == 3'd7)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            word_idx_reg <= 4'd0;
            step_reg     <= 4'd0;
            round_reg    <= '0;
            out_cnt_reg  <= 3'd0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            word_idx_reg <= word_idx_next;
            step_reg     <= step_next;
            round_reg    <= round_next;
            out_cnt_reg  <= out_cnt_next;
            fin_reg      <= fin_next;
        end
    end

`ifndef SYNTHESIS
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> busy)
        else $error("digest strobe while not busy");
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        digest_last |-> digest_valid)
        else $error("last marker without strobe");
    a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_cnt_reg == 3'd7) |=> (state_reg == S_IDLE))
        else $error("digest burst did not end after eight words");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("word loaded while compressing");
`endif

endmodule

FILE: rtl/b256_dpath.sv
// Datapath of the BLAKE-256 core: message store, work vector, G unit and chaining value.
module b256_dpath
    import b256_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  b256_cmd_t        cmd,
    input  logic [31:0]      message_word,
    input  logic [63:0]      bit_count,
    input  logic [3:0][31:0] salt,
    output logic [31:0]      digest_word
);

    logic [31:0]           msg_mem [0:15];
    logic [3:0]            wr_idx_reg;
    logic [31:0]           msg_q_reg;
    logic [31:0]           cst_q_reg;
    logic [63:0]           cnt_reg;
    logic [3:0][3:0][31:0] v_reg, v_next;
    logic [7:0][31:0]      cv_reg, cv_next;
    logic [3:0][3:0][31:0] g_out;
    logic [1:0]            rot_a, rot_b, rot_c, rot_d;
    logic [31:0]           x, a1, dx, d1, c1, bx, b1;

    function automatic logic [3:0][31:0] rot_row(input logic [3:0][31:0] r,
                                                 input logic [1:0] k);
        logic [3:0][31:0] o;
        for (int i = 0; i < 4; i++)
        begin
            o[i] = r[2'(i) + k];
        end
        return o;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            msg_mem[wr_idx_reg] <= message_word;
        end
        if (cmd.pf_en)
        begin
            msg_q_reg <= msg_mem[SIGMA[cmd.pf_row][cmd.pf_step]];
            cst_q_reg <= BLAKE_C[SIGMA[cmd.pf_row][cmd.pf_step ^ 4'd1]];
        end
        if (cmd.latch_cnt)
        begin
            cnt_reg <= bit_count;
        end
    end

    always_comb
    begin
        x  = msg_q_reg ^ cst_q_reg;
        a1 = v_reg[0][0] + v_reg[1][0] + x;
        dx = v_reg[3][0] ^ a1;
        d1 = cmd.g_half ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
        c1 = v_reg[2][0] + d1;
        bx = v_reg[1][0] ^ c1;
        b1 = cmd.g_half ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
        rot_a = 2'd1;
        rot_b = 2'd1;
        rot_c = 2'd1;
        rot_d = 2'd1;
        case (cmd.g_step)
            3'd3:
            begin
                rot_b = 2'd2;
                rot_c = 2'd3;
                rot_d = 2'd0;
            end
            3'd7:
            begin
                rot_b = 2'd0;
                rot_c = 2'd3;
                rot_d = 2'd2;
            end
            default:
            begin
                rot_a = 2'd1;
            end
        endcase
    end

    always_comb
    begin
        v_next  = v_reg;
        cv_next = cv_reg;
        if (cmd.load && cmd.first_iv)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cv_next[i] = BLAKE_IV[i];
            end
        end
        if (cmd.init)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_next[0][i] = cv_reg[i];
                v_next[1][i] = cv_reg[i + 4];
                v_next[2][i] = salt[i] ^ BLAKE_C[i];
            end
            v_next[3][0] = cnt_reg[31:0]  ^ BLAKE_C[4];
            v_next[3][1] = cnt_reg[31:0]  ^ BLAKE_C[5];
            v_next[3][2] = cnt_reg[63:32] ^ BLAKE_C[6];
            v_next[3][3] = cnt_reg[63:32] ^ BLAKE_C[7];
        end
        if (cmd.g_en)
        begin
            g_out = v_reg;
            g_out[0][0] = a1;
            g_out[1][0] = b1;
            g_out[2][0] = c1;
            g_out[3][0] = d1;
            if (cmd.g_half)
            begin
                v_next[0] = rot_row(g_out[0], rot_a);
                v_next[1] = rot_row(g_out[1], rot_b);
                v_next[2] = rot_row(g_out[2], rot_c);
                v_next[3] = rot_row(g_out[3], rot_d);
            end
            else
            begin
                v_next = g_out;
            end
        end
        else
        begin
            g_out = v_reg;
        end
        if (cmd.fin)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cv_next[i]     = cv_reg[i] ^ salt[i] ^ v_reg[0][i] ^ v_reg[2][i];
                cv_next[i + 4] = cv_reg[i + 4] ^ salt[i] ^ v_reg[1][i] ^ v_reg[3][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 4'd0;
            v_reg      <= '0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= BLAKE_IV[i];
            end
        end
        else
        begin
            if (cmd.load)
            begin
                wr_idx_reg <= wr_idx_reg + 4'd1;
            end
            v_reg  <= v_next;
            cv_reg <= cv_next;
        end
    end

    assign digest_word = cv_reg[cmd.out_sel];

endmodule

FILE: sim/blake256_checker.sv
// Checker that predicts BLAKE-256 digest words from observed transactions and compares them.
`timescale 1ns / 1ps
module blake256_checker
    import b256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] message_word,
    input  logic [63:0] bit_count,
    input  logic        first_block,
    input  logic        final_block,
    input  logic        digest_valid,
    input  logic [31:0] digest_word,
    input  logic        digest_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);

    localparam int NUM_ROUNDS = 14;
    localparam int LANE [0:7][0:3] = '{
        '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
        '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
    };

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_t;

    digest_t     digest_q [$];
    logic [31:0] chain [8];
    logic [31:0] msg [16];
    logic [31:0] salt [4];
    logic [3:0]  widx;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block(input logic [63:0] cnt);
        logic [31:0] v [16];
        logic [31:0] a, b, c, d;
        int p, q, row;
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 4; i++) v[8 + i] = salt[i] ^ BLAKE_C[i];
        v[12] = cnt[31:0] ^ BLAKE_C[4];
        v[13] = cnt[31:0] ^ BLAKE_C[5];
        v[14] = cnt[63:32] ^ BLAKE_C[6];
        v[15] = cnt[63:32] ^ BLAKE_C[7];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            row = r % 10;
            for (int s = 0; s < 8; s++) begin
                p = SIGMA[row][2 * s];
                q = SIGMA[row][2 * s + 1];
                a = v[LANE[s][0]];
                b = v[LANE[s][1]];
                c = v[LANE[s][2]];
                d = v[LANE[s][3]];
                a = a + b + (msg[p] ^ BLAKE_C[q]);
                d = rotr(d ^ a, 16);
                c = c + d;
                b = rotr(b ^ c, 12);
                a = a + b + (msg[q] ^ BLAKE_C[p]);
                d = rotr(d ^ a, 8);
                c = c + d;
                b = rotr(b ^ c, 7);
                v[LANE[s][0]] = a;
                v[LANE[s][1]] = b;
                v[LANE[s][2]] = c;
                v[LANE[s][3]] = d;
            end
        end
        for (int i = 0; i < 8; i++) chain[i] ^= salt[i % 4] ^ v[i] ^ v[i + 8];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_t exp_d;
        if (!rst_n) begin
            for (int i = 0; i < 8; i++) chain[i] = BLAKE_IV[i];
            for (int i = 0; i < 4; i++) salt[i] = '0;
            widx = '0;
            errors = 0;
            digest_q.delete();
        end else begin
            if (digest_valid) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word %h last %b", $time,
                             digest_word, digest_last);
                    errors++;
                end else begin
                    exp_d = digest_q.pop_front();
                    if (digest_word !== exp_d.word || digest_last !== exp_d.last) begin
                        $display("%0t: digest mismatch, expected %h last %b, got %h last %b",
                                 $time, exp_d.word, exp_d.last, digest_word, digest_last);
                        errors++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
                salt[paddr[3:2]] = pwdata;
            if (start && !busy) begin
                if (widx == 0 && first_block)
                    for (int i = 0; i < 8; i++) chain[i] = BLAKE_IV[i];
                msg[widx] = message_word;
                if (widx == 15) begin
                    compress_block(bit_count);
                    if (final_block)
                        for (int i = 0; i < 8; i++) begin
                            exp_d.word = chain[i];
                            exp_d.last = (i == 7);
                            digest_q.push_back(exp_d);
                        end
                end
                widx = widx + 1'b1;
            end
        end
        pending = digest_q.size();
    end

endmodule

FILE: sim/testbench.sv
// Top of the BLAKE-256 core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import b256_pkg::*;

    localparam logic [3:0] REG_SALT_0 = 4'd0;
    localparam logic [3:0] REG_SALT_1 = 4'd4;
    localparam logic [3:0] REG_SALT_2 = 4'd8;
    localparam logic [3:0] REG_SALT_3 = 4'd12;
    localparam int SETTLE_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] message_word = '0;
    logic [63:0] bit_count = '0;
    logic        first_block = 1'b0;
    logic        final_block = 1'b0;
    logic        digest_valid;
    logic [31:0] digest_word;
    logic        digest_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          burst_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    blake256_hash_core u_dut (.*);

    blake256_checker u_chk (.*);

    task automatic send_word(input logic [31:0] w, input logic [63:0] cnt,
                             input logic fb, input logic lb);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start <= 1'b1;
        message_word <= w;
        bit_count <= cnt;
        first_block <= fb;
        final_block <= lb;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_salt(input logic [3:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_salts(input logic [31:0] s0, input logic [31:0] s1,
                             input logic [31:0] s2, input logic [31:0] s3);
        drain();
        write_salt(REG_SALT_0, s0);
        write_salt(REG_SALT_1, s1);
        write_salt(REG_SALT_2, s2);
        write_salt(REG_SALT_3, s3);
    endtask

    task automatic random_block();
        logic [63:0] cnt;
        logic        fb;
        logic        lb;
        case ($urandom_range(0, 3))
            0: cnt = '0;
            1: cnt = '1;
            2: cnt = {$urandom, $urandom};
            default: cnt = 64'($urandom_range(0, 4096));
        endcase
        for (int w = 0; w < 16; w++) begin
            fb = (w == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
            lb = (w == 15) ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 7) == 0);
            send_word($urandom, cnt, fb, lb);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero block with stray flags on the middle words, then a chained all-ones block.
        for (int w = 0; w < 16; w++)
            send_word('0, '0, w == 0 || w == 5, w == 15 || w == 7);
        for (int w = 0; w < 16; w++)
            send_word('1, '1, 1'b0, w == 15);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_salts('1, '1, '1, '1);
                1: set_salts($urandom, $urandom, $urandom, $urandom);
                2: set_salts(32'hAAAAAAAA, 32'h55555555, 32'h80000001, 32'h00000001);
                default: set_salts('0, '0, '0, '0);
            endcase
            for (int b = 0; b < 2; b++) random_block();
        end

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: blake256_hash_core.f
rtl/b256_pkg.sv
rtl/b256_ctrl.sv
rtl/b256_dpath.sv
rtl/blake256_hash_core.sv
sim/blake256_checker.sv
sim/testbench.sv
